// File: rtl/lcps_pkg.sv
package lcps_pkg;

  // Field widths.
  localparam int NUM_FIELDS  = 5;
  localparam int TIME_W      = 12;
  localparam int TIME_SHIFT  = 5;
  localparam int SCALED_W    = TIME_W - TIME_SHIFT;
  localparam int MASS_W      = 10;
  localparam int TORQUE_W    = 11;
  localparam int GAIN_W      = 10;
  localparam int POS_W       = 12;
  localparam int SCALE_W     = 10;
  localparam int SPEED_W     = 8;
  localparam int DRIVE_W     = 24;
  localparam int ERR_W       = 13;
  localparam int INTEG_W     = 7;

  // Configuration port.
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_POS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_SCALE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_FLOOR   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_CEILING = 3'd7;

  // Loop constants.
  localparam int INTEG_LIMIT = 60;
  localparam int POS_MAX     = 4095;
  localparam int DRIVE_MAX   = 8388607;
  localparam int DRIVE_MIN   = -8388608;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] integ_gain;
    logic signed [GAIN_W-1:0] deriv_gain;
    logic [POS_W-1:0]         target_position;
    logic [SCALE_W-1:0]       position_scale;
    logic [SPEED_W-1:0]       base_speed;
    logic [SPEED_W-1:0]       speed_floor;
    logic [SPEED_W-1:0]       speed_ceiling;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    prop_gain:       '0,
    integ_gain:      '0,
    deriv_gain:      '0,
    target_position: '0,
    position_scale:  10'd1,
    base_speed:      '0,
    speed_floor:     '0,
    speed_ceiling:   8'd255
  };

  // One classified sensor frame waiting for the back end.
  typedef struct packed {
    logic [MASS_W-1:0]   mass;
    logic [TORQUE_W-1:0] torque;
    logic                no_line;
  } qentry_t;

endpackage

// File: rtl/lcps_front.sv
module lcps_front #(
  parameter int SENSOR_COUNT = 5
) (
  input  logic [lcps_pkg::NUM_FIELDS-1:0][lcps_pkg::TIME_W-1:0] sensor_time,
  output lcps_pkg::qentry_t                                     entry
);
  import lcps_pkg::*;

  logic [NUM_FIELDS-1:0][SCALED_W-1:0] scaled;
  logic [MASS_W-1:0]                   mass;
  logic [TORQUE_W-1:0]                 torque;

  // Scale each discharge time down by 32; sensors past the count read as zero.
  always_comb begin
    for (int i = 0; i < NUM_FIELDS; i++) begin
      if (i < SENSOR_COUNT) begin
        scaled[i] = sensor_time[i][TIME_W-1:TIME_SHIFT];
      end else begin
        scaled[i] = '0;
      end
    end
  end

  // Mass is the plain sum, torque weights each sensor by its index.
  always_comb begin
    mass   = '0;
    torque = '0;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      mass   = mass + MASS_W'(scaled[i]);
      torque = torque + TORQUE_W'(scaled[i]) * TORQUE_W'(i);
    end
  end

  // A frame with no reflectance at all means the line is lost.
  assign entry.mass    = mass;
  assign entry.torque  = torque;
  assign entry.no_line = (mass == '0);

endmodule

// File: rtl/lcps_queue.sv
module lcps_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  lcps_pkg::qentry_t   push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output lcps_pkg::qentry_t   pop_data
);
  import lcps_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qentry_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               push;
  logic               pop;

  assign push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/lcps_back.sv
module lcps_back #(
  parameter int LEFT_OFFSET  = 0,
  parameter int RIGHT_OFFSET = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lcps_pkg::cfg_t                        cfg,
  input  logic                                  q_valid,
  output logic                                  q_ready,
  input  lcps_pkg::qentry_t                     q_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [lcps_pkg::SPEED_W-1:0]          left_speed,
  output logic [lcps_pkg::SPEED_W-1:0]          right_speed,
  output logic [lcps_pkg::POS_W-1:0]            line_position,
  output logic signed [lcps_pkg::DRIVE_W-1:0]   drive_value,
  output logic                                  no_line
);
  import lcps_pkg::*;

  localparam int DVD_W      = TORQUE_W + SCALE_W;
  localparam int DIV_STEPS  = DVD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int D_W        = ERR_W + 1;
  localparam int ISUM_W     = ERR_W + 1;
  localparam int PPROD_W    = ERR_W + GAIN_W;
  localparam int IPROD_W    = INTEG_W + GAIN_W;
  localparam int DPROD_W    = D_W + GAIN_W;
  localparam int DSUM_W     = DPROD_W + 2;
  localparam int MIX_W      = DSUM_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ERR,
    S_PROD,
    S_SUM,
    S_MIX
  } state_t;

  state_t                     state_r, state_nxt;
  logic [DIV_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [DVD_W-1:0]           dvd_r, dvd_nxt;
  logic [MASS_W-1:0]          rem_r, rem_nxt;
  logic [MASS_W-1:0]          mass_r, mass_nxt;
  logic                       none_r, none_nxt;
  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic signed [ERR_W-1:0]    err_r, err_nxt;
  logic signed [D_W-1:0]      d_r, d_nxt;
  logic signed [ERR_W-1:0]    prev_err_r, prev_err_nxt;
  logic signed [INTEG_W-1:0]  integ_r, integ_nxt;
  logic signed [PPROD_W-1:0]  p_prod_r, p_prod_nxt;
  logic signed [IPROD_W-1:0]  i_prod_r, i_prod_nxt;
  logic signed [DPROD_W-1:0]  d_prod_r, d_prod_nxt;
  logic signed [DRIVE_W-1:0]  drive_r, drive_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [SPEED_W-1:0]         left_r, left_nxt;
  logic [SPEED_W-1:0]         right_r, right_nxt;
  logic [POS_W-1:0]           out_pos_r, out_pos_nxt;
  logic signed [DRIVE_W-1:0]  out_drive_r, out_drive_nxt;
  logic                       out_none_r, out_none_nxt;

  logic [MASS_W:0]            rem_sh;
  logic [MASS_W:0]            rem_diff;
  logic                       div_ge;
  logic [POS_W-1:0]           pos_sat;
  logic signed [ERR_W-1:0]    err_calc;
  logic signed [ISUM_W-1:0]   integ_sum;
  logic signed [DSUM_W-1:0]   drive_sum;
  logic signed [MIX_W-1:0]    left_mix;
  logic signed [MIX_W-1:0]    right_mix;
  logic                       out_free;

  // Clamp a mixed speed to the floor first, then to the ceiling.
  function automatic logic [SPEED_W-1:0] clamp_speed(
    input logic signed [MIX_W-1:0] x,
    input logic [SPEED_W-1:0]      lo,
    input logic [SPEED_W-1:0]      hi
  );
    logic signed [MIX_W-1:0] lo_s;
    logic signed [MIX_W-1:0] hi_s;
    lo_s = $signed({{(MIX_W-SPEED_W){1'b0}}, lo});
    hi_s = $signed({{(MIX_W-SPEED_W){1'b0}}, hi});
    if (x < lo_s) begin
      return lo;
    end else if (x > hi_s) begin
      return hi;
    end
    return x[SPEED_W-1:0];
  endfunction

  assign q_ready  = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // One restoring division step: quotient bits shift in behind the dividend.
  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign rem_diff = rem_sh - {1'b0, mass_r};
  assign div_ge   = (rem_sh >= {1'b0, mass_r});

  // Position saturation and error against the target.
  assign pos_sat   = (dvd_r > DVD_W'(POS_MAX)) ? POS_W'(POS_MAX) : dvd_r[POS_W-1:0];
  assign err_calc  = $signed({1'b0, pos_sat}) - $signed({1'b0, cfg.target_position});
  assign integ_sum = ISUM_W'(integ_r) + ISUM_W'(err_calc);

  // Sum of the three PID terms.
  assign drive_sum = DSUM_W'(p_prod_r) + DSUM_W'(i_prod_r) + DSUM_W'(d_prod_r);

  // Differential mixing around the base speed.
  assign left_mix  = MIX_W'(drive_r) + $signed({{(MIX_W-SPEED_W){1'b0}}, cfg.base_speed})
                   + MIX_W'(LEFT_OFFSET);
  assign right_mix = $signed({{(MIX_W-SPEED_W){1'b0}}, cfg.base_speed}) - MIX_W'(drive_r)
                   + MIX_W'(RIGHT_OFFSET);

  // Sequencer next-state and datapath next values.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    mass_nxt      = mass_r;
    none_nxt      = none_r;
    pos_nxt       = pos_r;
    err_nxt       = err_r;
    d_nxt         = d_r;
    prev_err_nxt  = prev_err_r;
    integ_nxt     = integ_r;
    p_prod_nxt    = p_prod_r;
    i_prod_nxt    = i_prod_r;
    d_prod_nxt    = d_prod_r;
    drive_nxt     = drive_r;
    out_valid_nxt = out_valid_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    out_pos_nxt   = out_pos_r;
    out_drive_nxt = out_drive_r;
    out_none_nxt  = out_none_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        // Take an item and scale its torque; a lost line skips the divider.
        if (q_valid) begin
          mass_nxt = q_data.mass;
          none_nxt = q_data.no_line;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          if (q_data.no_line) begin
            dvd_nxt   = '0;
            state_nxt = S_ERR;
          end else begin
            dvd_nxt   = DVD_W'(q_data.torque) * DVD_W'(cfg.position_scale);
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_nxt = div_ge ? rem_diff[MASS_W-1:0] : rem_sh[MASS_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], div_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        // Error, derivative and clamped integral; loop state advances here.
        pos_nxt      = pos_sat;
        err_nxt      = err_calc;
        d_nxt        = D_W'(err_calc) - D_W'(prev_err_r);
        prev_err_nxt = err_calc;
        if (integ_sum < ISUM_W'(-INTEG_LIMIT)) begin
          integ_nxt = INTEG_W'(-INTEG_LIMIT);
        end else if (integ_sum > ISUM_W'(INTEG_LIMIT)) begin
          integ_nxt = INTEG_W'(INTEG_LIMIT);
        end else begin
          integ_nxt = integ_sum[INTEG_W-1:0];
        end
        state_nxt = S_PROD;
      end
      S_PROD: begin
        p_prod_nxt = PPROD_W'(err_r) * PPROD_W'(cfg.prop_gain);
        i_prod_nxt = IPROD_W'(integ_r) * IPROD_W'(cfg.integ_gain);
        d_prod_nxt = DPROD_W'(d_r) * DPROD_W'(cfg.deriv_gain);
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        if (drive_sum > DSUM_W'(DRIVE_MAX)) begin
          drive_nxt = DRIVE_W'(DRIVE_MAX);
        end else if (drive_sum < DSUM_W'(DRIVE_MIN)) begin
          drive_nxt = DRIVE_W'(DRIVE_MIN);
        end else begin
          drive_nxt = drive_sum[DRIVE_W-1:0];
        end
        state_nxt = S_MIX;
      end
      S_MIX: begin
        // Hold here until the output register can take the result.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          left_nxt      = clamp_speed(left_mix, cfg.speed_floor, cfg.speed_ceiling);
          right_nxt     = clamp_speed(right_mix, cfg.speed_floor, cfg.speed_ceiling);
          out_pos_nxt   = pos_r;
          out_drive_nxt = drive_r;
          out_none_nxt  = none_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      prev_err_r  <= '0;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      prev_err_r  <= prev_err_nxt;
      integ_r     <= integ_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    mass_r      <= mass_nxt;
    none_r      <= none_nxt;
    pos_r       <= pos_nxt;
    err_r       <= err_nxt;
    d_r         <= d_nxt;
    p_prod_r    <= p_prod_nxt;
    i_prod_r    <= i_prod_nxt;
    d_prod_r    <= d_prod_nxt;
    drive_r     <= drive_nxt;
    left_r      <= left_nxt;
    right_r     <= right_nxt;
    out_pos_r   <= out_pos_nxt;
    out_drive_r <= out_drive_nxt;
    out_none_r  <= out_none_nxt;
  end

  assign out_valid     = out_valid_r;
  assign left_speed    = left_r;
  assign right_speed   = right_r;
  assign line_position = out_pos_r;
  assign drive_value   = out_drive_r;
  assign no_line       = out_none_r;

endmodule

// File: rtl/line_centroid_pid_steering.sv
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    in_sensor_time_0 .. in_sensor_time_4
// out_     output     out_valid / out_ready  out_left_speed, out_right_speed,
//                                            out_line_position, out_drive_value, out_no_line
// cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// When the line is seen, the back end loads an item, scales its torque, runs 21 steps of
// the bit-serial position divider, then the error, product, sum and mix states of PID and
// mixing; a lost line skips the divider. No new item is taken until the last leaves the mix
// state. The front end and a two-entry queue take items while the back end works or while
// a result waits in the output register. Reset is synchronous and active low; it clears the
// loop state and loads the register defaults. Configuration writes are taken every cycle.
module line_centroid_pid_steering #(
  parameter int SENSOR_COUNT = 5,
  parameter int LEFT_OFFSET  = 0,
  parameter int RIGHT_OFFSET = 0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [lcps_pkg::TIME_W-1:0]          in_sensor_time_0,
  input  logic [lcps_pkg::TIME_W-1:0]          in_sensor_time_1,
  input  logic [lcps_pkg::TIME_W-1:0]          in_sensor_time_2,
  input  logic [lcps_pkg::TIME_W-1:0]          in_sensor_time_3,
  input  logic [lcps_pkg::TIME_W-1:0]          in_sensor_time_4,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [lcps_pkg::SPEED_W-1:0]         out_left_speed,
  output logic [lcps_pkg::SPEED_W-1:0]         out_right_speed,
  output logic [lcps_pkg::POS_W-1:0]           out_line_position,
  output logic signed [lcps_pkg::DRIVE_W-1:0]  out_drive_value,
  output logic                                 out_no_line,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lcps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lcps_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lcps_pkg::*;

  cfg_t                                cfg_r;
  logic [NUM_FIELDS-1:0][TIME_W-1:0]   sensor_time;
  qentry_t                             front_entry;
  qentry_t                             q_data;
  logic                                q_valid;
  logic                                q_ready;

  // Register file; every index of the port maps to a register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROP_GAIN:     cfg_r.prop_gain       <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:    cfg_r.integ_gain      <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:    cfg_r.deriv_gain      <= cfg_data[GAIN_W-1:0];
        REG_TARGET_POS:    cfg_r.target_position <= cfg_data[POS_W-1:0];
        REG_POS_SCALE:     cfg_r.position_scale  <= cfg_data[SCALE_W-1:0];
        REG_BASE_SPEED:    cfg_r.base_speed      <= cfg_data[SPEED_W-1:0];
        REG_SPEED_FLOOR:   cfg_r.speed_floor     <= cfg_data[SPEED_W-1:0];
        REG_SPEED_CEILING: cfg_r.speed_ceiling   <= cfg_data[SPEED_W-1:0];
        default:           cfg_r                 <= cfg_r;
      endcase
    end
  end

  // Front end: mass, torque and line-lost classification.
  assign sensor_time = {in_sensor_time_4, in_sensor_time_3, in_sensor_time_2,
                        in_sensor_time_1, in_sensor_time_0};

  lcps_front #(
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_front (
    .sensor_time (sensor_time),
    .entry       (front_entry)
  );

  // Queue between classification and the division and PID back end.
  lcps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  lcps_back #(
    .LEFT_OFFSET  (LEFT_OFFSET),
    .RIGHT_OFFSET (RIGHT_OFFSET)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_data        (q_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .left_speed    (out_left_speed),
    .right_speed   (out_right_speed),
    .line_position (out_line_position),
    .drive_value   (out_drive_value),
    .no_line       (out_no_line)
  );

  // A lost line always reports position zero.
  a_no_line_pos : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_line |-> out_line_position == '0)
    else $error("line lost but position is not zero");

  // With sane bounds both speeds stay inside them.
  a_speed_bounds : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (cfg_r.speed_floor <= cfg_r.speed_ceiling) |->
      (out_left_speed >= cfg_r.speed_floor) && (out_left_speed <= cfg_r.speed_ceiling) &&
      (out_right_speed >= cfg_r.speed_floor) && (out_right_speed <= cfg_r.speed_ceiling))
    else $error("motor speed outside configured bounds");

  // The scaled position can never exceed what the scale allows for five sensors.
  a_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_position <= {cfg_r.position_scale, 2'b00})
    else $error("line position beyond four times the scale");

endmodule
